FILE: rtl/point_in_polygon_ray_cast_defines.svh
// Assertion macros shared by the point-in-polygon checker.
`ifndef POINT_IN_POLYGON_RAY_CAST_DEFINES_SVH
`define POINT_IN_POLYGON_RAY_CAST_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppr assertion failed");

`endif

FILE: rtl/ppr_pkg.sv
// Types and constants of the point-in-polygon ray-cast block.
`timescale 1ns / 1ps
package ppr_pkg;

  localparam int CoordW = 12;
  localparam int AngW   = 16;
  localparam int RotW   = 29;
  localparam int DifW   = 30;
  localparam int PrdW   = 60;
  localparam int CfgIdxW = 1;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_TEST  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_COS = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_SIN = 1'd1;

  localparam logic signed [AngW-1:0] COS_RESET = 16'sd32480;
  localparam logic signed [AngW-1:0] SIN_RESET = -16'sd4337;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic                     side_bit;
  } item_t;

  typedef struct packed {
    logic inside_res;
    logic store_full;
  } res_t;

  typedef struct packed {
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } vtx_t;

  typedef struct packed {
    logic vld;
    logic first;
  } tag_t;

  typedef struct packed {
    logic signed [RotW-1:0] xr;
    logic signed [RotW-1:0] yr;
    tag_t                   tag;
  } rot_t;

endpackage

FILE: rtl/ppr_cell.sv
// One vertex cell of the polygon ring.
`timescale 1ns / 1ps
module ppr_cell
  import ppr_pkg::*;
(
  input  logic clk_i,
  input  logic shift_i,
  input  logic rot_i,
  input  vtx_t prev_i,
  input  vtx_t next_i,
  output vtx_t vtx_o
);

  vtx_t vtx_q;

  // shift pushes a new vertex in at the head; rot hands the ring one step back
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      vtx_q <= prev_i;
    end else if (rot_i) begin
      vtx_q <= next_i;
    end
  end

  assign vtx_o = vtx_q;

endmodule

FILE: rtl/ppr_rotate.sv
// Registered rotation of one point by the beam angle.
`timescale 1ns / 1ps
module ppr_rotate
  import ppr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  vtx_t                   vtx_i,
  input  tag_t                   tag_i,
  input  logic signed [AngW-1:0] cos_i,
  input  logic signed [AngW-1:0] sin_i,
  output rot_t                   rot_o
);

  logic signed [CoordW+AngW-1:0] xc, xs, yc, ys;
  logic signed [RotW-1:0]        xr_d, yr_d, xr_q, yr_q;
  tag_t                          tag_q;

  assign xc   = vtx_i.x * cos_i;
  assign xs   = vtx_i.x * sin_i;
  assign yc   = vtx_i.y * cos_i;
  assign ys   = vtx_i.y * sin_i;
  assign xr_d = RotW'(xc) - RotW'(ys);
  assign yr_d = RotW'(xs) + RotW'(yc);

  always_ff @(posedge clk_i) begin
    xr_q <= xr_d;
    yr_q <= yr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  assign rot_o = '{xr: xr_q, yr: yr_q, tag: tag_q};

endmodule

FILE: rtl/ppr_edge.sv
// Edge crossing test and even-odd accumulator.
`timescale 1ns / 1ps
module ppr_edge
  import ppr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic clear_i,
  input  logic pt_load_i,
  input  rot_t rot_i,
  output logic odd_o
);

  logic signed [RotW-1:0] px_q, py_q, bx_q, by_q;
  logic signed [DifW-1:0] dy, dx, ex, d;
  logic signed [PrdW-1:0] lhs_q, rhs_q;
  logic                   cross_d, cross_q, dpos_q, odd_q, hit;

  assign dy = DifW'(py_q) - DifW'(rot_i.yr);
  assign dx = DifW'(bx_q) - DifW'(rot_i.xr);
  assign ex = DifW'(px_q) - DifW'(rot_i.xr);
  assign d  = DifW'(by_q) - DifW'(rot_i.yr);
  assign cross_d = rot_i.tag.vld && !rot_i.tag.first &&
                   ((rot_i.yr < py_q) != (by_q < py_q));

  always_ff @(posedge clk_i) begin
    if (pt_load_i) begin
      px_q <= rot_i.xr;
      py_q <= rot_i.yr;
    end
    if (rot_i.tag.vld) begin
      bx_q <= rot_i.xr;
      by_q <= rot_i.yr;
    end
    lhs_q  <= dy * dx;
    rhs_q  <= ex * d;
    dpos_q <= (by_q > rot_i.yr);
  end

  assign hit = dpos_q ? (lhs_q < rhs_q) : (lhs_q > rhs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cross_q <= 1'b0;
      odd_q   <= 1'b0;
    end else begin
      cross_q <= cross_d && !clear_i;
      if (clear_i) begin
        odd_q <= 1'b0;
      end else if (cross_q && hit) begin
        odd_q <= !odd_q;
      end
    end
  end

  assign odd_o = odd_q;

endmodule

FILE: rtl/point_in_polygon_ray_cast.sv
// Top level of the point-in-polygon ray-cast block.
`timescale 1ns / 1ps
// Usage:
//   Command channel: drive item_i and raise start_i; the item is taken at a
//   rising edge with start_i high and busy_o low. Actions: clear (empty the
//   polygon, set the owner bit), add (append a vertex), test (check a point).
//   Every item gives exactly one result on res_o, flagged by res_valid_o for
//   one cycle. The receiver cannot stall; take the result when it is flagged.
//   Clear, add, unused codes, and tests that answer at once (side bit equals
//   owner, or empty polygon) give their result on the cycle after acceptance
//   and keep busy_o low, so such items can follow every cycle.
//   A full test keeps busy_o high while it runs: S_ROT rotates the point,
//   then in S_WALK the vertex ring makes one full turn, feeding each vertex
//   and then the first vertex again through the shared rotation unit;
//   S_DRAIN drains the crossing pipeline, and the result is registered.
//   Configuration: cfg_valid_i with cfg_index_i and cfg_data_i writes the
//   cosine (index 0) or sine (index 1) register; cfg_ready_o is always high.
//   Reset clears the vertex count and owner bit and loads cos/sin of 25 rad;
//   vertex cells are not cleared, since only written cells are read.
module point_in_polygon_ray_cast
  import ppr_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  item_t                  item_i,
  output logic                   busy_o,
  output logic                   res_valid_o,
  output res_t                   res_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic signed [AngW-1:0] cfg_data_i
);

  localparam int CntW = $clog2(MAX_VERTICES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_VERTICES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ROT   = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d, k_q, k_d;
  logic [1:0]             drn_q, drn_d;
  logic                   owner_q, owner_d;
  logic signed [AngW-1:0] cos_q, sin_q;
  logic                   res_valid_q, res_valid_d;
  res_t                   res_q, res_d;
  vtx_t                   pt_q, first_q, rot_vtx;
  tag_t                   rot_tag;
  rot_t                   rot;
  logic                   accept, add_shift, ring_rot, odd, clear_odd, pt_load;
  vtx_t                   cell_v [MAX_VERTICES];
  vtx_t                   new_vtx;

  assign accept      = start_i && (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign new_vtx     = '{y: item_i.pos_y, x: item_i.pos_x};

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= COS_RESET;
      sin_q <= SIN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_COS: cos_q <= cfg_data_i;
        REG_SIN: sin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control: one item at a time; a non-trivial test walks the whole ring
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    drn_d       = drn_q;
    owner_d     = owner_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    add_shift   = 1'b0;
    clear_odd   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          res_d       = '0;
          unique case (item_i.action)
            ACT_CLEAR: begin
              cnt_d   = '0;
              owner_d = item_i.side_bit;
            end
            ACT_ADD: begin
              if (cnt_q < MaxCnt) begin
                add_shift = 1'b1;
                cnt_d     = cnt_q + 1'b1;
              end else begin
                res_d.store_full = 1'b1;
              end
            end
            ACT_TEST: begin
              if ((item_i.side_bit != owner_q) && (cnt_q != '0)) begin
                // hold the result until the walk ends
                res_valid_d = 1'b0;
                clear_odd   = 1'b1;
                k_d         = '0;
                state_d     = S_ROT;
              end
            end
            default: ;
          endcase
        end
      end
      S_ROT: begin
        state_d = S_WALK;
      end
      S_WALK: begin
        if (k_q == MaxCnt) begin
          drn_d   = '0;
          state_d = S_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_DRAIN: begin
        drn_d = drn_q + 1'b1;
        if (drn_q == 2'd2) begin
          res_valid_d      = 1'b1;
          res_d            = '0;
          res_d.inside_res = odd;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      drn_q       <= '0;
      owner_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      drn_q       <= drn_d;
      owner_q     <= owner_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers: result, tested point, first vertex of the walk
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      pt_q <= new_vtx;
    end
    if ((state_q == S_WALK) && (k_q == '0)) begin
      first_q <= cell_v[0];
    end
  end

  // Vertex ring: newest vertex sits at cell 0; a test turns the ring once
  assign ring_rot = (state_q == S_WALK) && (k_q < MaxCnt);

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    if (i == 0) begin : g_head
      ppr_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(add_shift),
        .rot_i  (ring_rot),
        .prev_i (new_vtx),
        .next_i (cell_v[(i + 1) % MAX_VERTICES]),
        .vtx_o  (cell_v[i])
      );
    end else begin : g_body
      ppr_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(add_shift),
        .rot_i  (ring_rot),
        .prev_i (cell_v[i - 1]),
        .next_i (cell_v[(i + 1) % MAX_VERTICES]),
        .vtx_o  (cell_v[i])
      );
    end
  end

  // Feed the rotation unit: point first, then each vertex, then the first
  // vertex again to close the polygon
  always_comb begin
    rot_tag = '0;
    rot_vtx = pt_q;
    if (state_q == S_WALK) begin
      rot_tag.vld   = (k_q <= cnt_q);
      rot_tag.first = (k_q == '0);
      rot_vtx       = (k_q < cnt_q) ? cell_v[0] : first_q;
    end
  end

  assign pt_load = (state_q == S_WALK) && (k_q == '0);

  ppr_rotate u_rotate (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vtx_i (rot_vtx),
    .tag_i (rot_tag),
    .cos_i (cos_q),
    .sin_i (sin_q),
    .rot_o (rot)
  );

  ppr_edge u_edge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (clear_odd),
    .pt_load_i(pt_load),
    .rot_i    (rot),
    .odd_o    (odd)
  );

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/ppr_checker.sv
// Port-level checker for the point-in-polygon block, bound to the top level.
`timescale 1ns / 1ps
`include "point_in_polygon_ray_cast_defines.svh"
module ppr_checker
  import ppr_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  start_i,
  input item_t item_i,
  input logic  busy_o,
  input logic  res_valid_o,
  input res_t  res_o
);

  logic acc, acc_add, both_flags;

  assign acc        = start_i && !busy_o;
  assign acc_add    = acc && (item_i.action == ACT_ADD);
  assign both_flags = res_o.inside_res && res_o.store_full;

  // an accepted item either answers next cycle or keeps the block busy
  `PPR_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, acc, res_valid_o || busy_o)
  // a finished test always drops busy together with its result
  `PPR_ASSERT_NOW(a_done_has_result, clk_i, rst_ni, $fell(busy_o), res_valid_o)
  // no result is both an answer and a dropped vertex
  `PPR_ASSERT_NOW(a_flags_exclusive, clk_i, rst_ni, res_valid_o, !both_flags)
  // a full flag only follows an accepted add
  `PPR_ASSERT_NOW(a_full_after_add, clk_i, rst_ni, res_valid_o && res_o.store_full, $past(acc_add))

endmodule

bind point_in_polygon_ray_cast ppr_checker u_ppr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .item_i     (item_i),
  .busy_o     (busy_o),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);
